>>> sv/wtf16d_pkg.sv
// ----------------------------------------------------------------------------
// wtf16d_pkg
// Shared constants, types and helpers of the WTF-16 surrogate decoder.
// ----------------------------------------------------------------------------
package wtf16d_pkg;

	localparam int UNIT_W  = 16;
	localparam int POINT_W = 21;
	localparam int HALF_W  = 10;

	localparam logic [UNIT_W-1:0]  HIGH_FIRST = 16'hD800;
	localparam logic [UNIT_W-1:0]  HIGH_LAST  = 16'hDBFF;
	localparam logic [UNIT_W-1:0]  LOW_FIRST  = 16'hDC00;
	localparam logic [UNIT_W-1:0]  LOW_LAST   = 16'hDFFF;
	localparam logic [POINT_W-1:0] SUPP_BASE  = 21'h10000;

	// One decoded item as it waits in the queue: one or two code points.
	typedef struct packed {
		logic               two;
		logic [POINT_W-1:0] cp_a;
		logic [POINT_W-1:0] cp_b;
	} wtf16d_op_t;

	function automatic logic is_high(input logic [UNIT_W-1:0] u);
		return (u >= HIGH_FIRST) && (u <= HIGH_LAST);
	endfunction

	function automatic logic is_low(input logic [UNIT_W-1:0] u);
		return (u >= LOW_FIRST) && (u <= LOW_LAST);
	endfunction

endpackage

>>> sv/wtf16d_if.sv
// ----------------------------------------------------------------------------
// wtf16d_unit_if / wtf16d_point_if
// Valid/ready channels for code unit words and code point words.
// ----------------------------------------------------------------------------
interface wtf16d_unit_if;
	logic                           valid;
	logic                           ready;
	logic [wtf16d_pkg::UNIT_W-1:0]  code_unit;
	logic                           stream_end;

	modport source (output valid, output code_unit, output stream_end, input ready);
	modport sink   (input valid, input code_unit, input stream_end, output ready);
endinterface

interface wtf16d_point_if;
	logic                           valid;
	logic                           ready;
	logic [wtf16d_pkg::POINT_W-1:0] code_point;
	logic                           last_of_item;

	modport source (output valid, output code_point, output last_of_item, input ready);
	modport sink   (input valid, input code_point, input last_of_item, output ready);
endinterface

>>> sv/wtf16d_front.sv
// ----------------------------------------------------------------------------
// wtf16d_front
// Accepts code units, tracks a held high surrogate and pushes decoded ops.
// ----------------------------------------------------------------------------
module wtf16d_front (
	input  logic                   clk,
	input  logic                   arst_n,
	wtf16d_unit_if.sink            din,
	output logic                   push_valid,
	output wtf16d_pkg::wtf16d_op_t push_op,
	input  logic                   push_ready
);
	import wtf16d_pkg::*;

	logic              pending_q;
	logic [HALF_W-1:0] held_q;
	logic              accept;
	logic              produce;
	logic              next_pending;
	logic [HALF_W-1:0] next_held;
	logic [POINT_W-1:0] held_point;
	logic [POINT_W-1:0] unit_point;
	logic [POINT_W-1:0] pair_point;

	// A word is taken whenever the queue has room.
	assign din.ready = push_ready;
	assign accept    = din.valid && push_ready;

	assign held_point = {{(POINT_W-UNIT_W){1'b0}}, HIGH_FIRST | {6'b0, held_q}};
	assign unit_point = {{(POINT_W-UNIT_W){1'b0}}, din.code_unit};
	assign pair_point = SUPP_BASE
		+ {{(POINT_W-2*HALF_W){1'b0}}, held_q, din.code_unit[HALF_W-1:0]};

	// Classify the word against the held state.
	always_comb begin
		produce      = 1'b0;
		next_pending = pending_q;
		next_held    = held_q;
		push_op.two  = 1'b0;
		push_op.cp_a = unit_point;
		push_op.cp_b = unit_point;
		if (din.stream_end) begin
			produce      = pending_q;
			push_op.cp_a = held_point;
			next_pending = 1'b0;
			next_held    = '0;
		end else if (pending_q && is_low(din.code_unit)) begin
			produce      = 1'b1;
			push_op.cp_a = pair_point;
			next_pending = 1'b0;
			next_held    = '0;
		end else if (is_high(din.code_unit)) begin
			produce      = pending_q;
			push_op.cp_a = held_point;
			next_pending = 1'b1;
			next_held    = din.code_unit[HALF_W-1:0];
		end else begin
			produce      = 1'b1;
			push_op.two  = pending_q;
			push_op.cp_a = pending_q ? held_point : unit_point;
			next_pending = 1'b0;
			next_held    = '0;
		end
	end

	assign push_valid = accept && produce;

	// Held surrogate state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			held_q    <= '0;
		end else if (accept) begin
			pending_q <= next_pending;
			held_q    <= next_held;
		end
	end

endmodule

>>> sv/wtf16d_queue.sv
// ----------------------------------------------------------------------------
// wtf16d_queue
// Two-entry queue of decoded ops between the front and the back.
// ----------------------------------------------------------------------------
module wtf16d_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	input  wtf16d_pkg::wtf16d_op_t push_op,
	output logic                   push_ready,
	output logic                   pop_valid,
	output wtf16d_pkg::wtf16d_op_t pop_op,
	input  logic                   pop_ready
);
	import wtf16d_pkg::*;

	wtf16d_op_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_op     = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

>>> sv/wtf16d_back.sv
// ----------------------------------------------------------------------------
// wtf16d_back
// Takes ops from the queue and emits their code points through an output
// register, one word per cycle while dout.ready is high.
// ----------------------------------------------------------------------------
module wtf16d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	input  wtf16d_pkg::wtf16d_op_t pop_op,
	output logic                   pop_ready,
	wtf16d_point_if.source         dout
);
	import wtf16d_pkg::*;

	logic               out_valid_q;
	logic [POINT_W-1:0] cp_q;
	logic               last_q;
	logic               second_q;
	logic               load;

	// The output register may be refilled when empty or being taken.
	assign load      = !out_valid_q || dout.ready;
	assign pop_ready = load && (!pop_op.two || second_q);

	assign dout.valid        = out_valid_q;
	assign dout.code_point   = cp_q;
	assign dout.last_of_item = last_q;

	// Output register and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= pop_valid;
			if (pop_valid && pop_op.two) begin
				second_q <= ~second_q;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			cp_q   <= second_q ? pop_op.cp_b : pop_op.cp_a;
			last_q <= !pop_op.two || second_q;
		end
	end

	a_second_head: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (pop_valid && pop_op.two))
		else $error("second result pending without a two-result op at the head");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q && dout.ready) |=> (out_valid_q && last_q))
		else $error("second result of an item did not follow the first");

	a_pop_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready && pop_op.two) |-> second_q)
		else $error("two-result op popped before its first result");

endmodule

>>> sv/wtf16_surrogate_decoder.sv
// ----------------------------------------------------------------------------
// wtf16_surrogate_decoder
// WTF-16 code unit to code point decoder.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one 16-bit code unit word per handshake, or an end-of-stream
//   word (stream_end set, code_unit ignored). dout carries code point words;
//   last_of_item marks the final word caused by one input word.
//   A high surrogate is held until the next word: a following low surrogate
//   forms a pair, anything else releases it alone. End of stream flushes it.
//   A result is offered on dout once the front has written its queue entry
//   at the edge that takes the input word and the back has then loaded that
//   entry into the output register, which waits while dout is stalled.
//   din takes one input word per cycle while the queue has room; a word
//   that yields two code points holds the output register for both of its
//   words, so sustained input then slows once the two-entry queue fills.
//   Reset clears the held surrogate, the queue and the output register.
//   When the receiver stalls, the output word holds, the queue fills and
//   din.ready falls after two further ops have been queued.
// ----------------------------------------------------------------------------
module wtf16_surrogate_decoder (
	input  logic            clk,
	input  logic            arst_n,
	wtf16d_unit_if.sink     din,
	wtf16d_point_if.source  dout
);
	import wtf16d_pkg::*;

	logic       push_valid;
	logic       push_ready;
	wtf16d_op_t push_op;
	logic       pop_valid;
	logic       pop_ready;
	wtf16d_op_t pop_op;

	wtf16d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready)
	);

	wtf16d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop_ready  (pop_ready)
	);

	wtf16d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_op    (pop_op),
		.pop_ready (pop_ready),
		.dout      (dout)
	);

endmodule
